### sv/bps_pkg.sv
// shared types, register indexes and pattern codes for the beep pattern sequencer
package bps_pkg;

    localparam int TIME_W   = 32;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 4;
    localparam int PAT_W    = 2;
    localparam int CNT_W    = $clog2(TIME_W);

    // pattern codes, same encoding as the mode input
    localparam logic [PAT_W-1:0] PAT_OFF   = 2'd0;
    localparam logic [PAT_W-1:0] PAT_SLOW  = 2'd1;
    localparam logic [PAT_W-1:0] PAT_FAST  = 2'd2;
    localparam logic [PAT_W-1:0] PAT_FAULT = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SLOW_PERIOD        = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SLOW_ON_TIME       = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FAST_PERIOD        = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FAST_ON_TIME       = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FAULT_PERIOD       = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FAULT_FIRST_END    = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FAULT_SECOND_START = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_FAULT_SECOND_END   = 4'd7;

    // reset values of the timing registers
    localparam logic [CFG_W-1:0] RST_SLOW_PERIOD        = 16'd1000;
    localparam logic [CFG_W-1:0] RST_SLOW_ON_TIME       = 16'd200;
    localparam logic [CFG_W-1:0] RST_FAST_PERIOD        = 16'd250;
    localparam logic [CFG_W-1:0] RST_FAST_ON_TIME       = 16'd100;
    localparam logic [CFG_W-1:0] RST_FAULT_PERIOD       = 16'd2000;
    localparam logic [CFG_W-1:0] RST_FAULT_FIRST_END    = 16'd150;
    localparam logic [CFG_W-1:0] RST_FAULT_SECOND_START = 16'd300;
    localparam logic [CFG_W-1:0] RST_FAULT_SECOND_END   = 16'd450;

    // timing register bank as seen by the sequencer
    typedef struct packed {
        logic [CFG_W-1:0] slow_period;
        logic [CFG_W-1:0] slow_on_time;
        logic [CFG_W-1:0] fast_period;
        logic [CFG_W-1:0] fast_on_time;
        logic [CFG_W-1:0] fault_period;
        logic [CFG_W-1:0] fault_first_end;
        logic [CFG_W-1:0] fault_second_start;
        logic [CFG_W-1:0] fault_second_end;
    } bps_cfg_t;

    // request to the remainder unit
    typedef struct packed {
        logic              start;
        logic [TIME_W-1:0] dividend;
        logic [CFG_W-1:0]  divisor;
    } bps_rem_req_t;

    // answer from the remainder unit
    typedef struct packed {
        logic             busy;
        logic             done;
        logic [CFG_W-1:0] rem;
    } bps_rem_rsp_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_OUT  = 3'b100
    } bps_state_t;

endpackage

### sv/beep_pattern_sequencer_top.sv
// beep pattern sequencer: request channel, timing registers and buzzer word out
//
// Each word on the s_ channel requests a pattern (s_mode) at time s_now_ms.
// A pattern different from the held one restarts the pattern clock at that
// time. The m_ channel returns one word per request: m_buzzer_on and the
// pattern now held (m_pattern_in_use).
// Timing registers are written through cfg_valid/cfg_ready/cfg_index/cfg_data
// and should only be changed while no request is in flight; cfg_ready is
// always high, indexes beyond the eight registers are ignored.
// The elapsed time is reduced modulo the period by a bit-serial remainder
// unit in ST_DIV; the buzzer word is then loaded into the output register
// in ST_OUT, which waits until the old word has been taken; off or a zero
// period skips the remainder unit and goes straight to ST_OUT.
// s_ready is high only while the sequencer is idle, so one request is in
// work at a time; the next request is accepted once the previous one has
// been loaded into the output register.
// The result sits in an output register: a new request is accepted while it
// waits, but a finished request is held until m_ready takes the old word.
// Reset (aresetn low, synchronous) restores the timing registers to their
// defaults, drops the held pattern to off with start time 0, empties output.
module beep_pattern_sequencer_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [bps_pkg::PAT_W-1:0]     s_mode,
    input  logic [bps_pkg::TIME_W-1:0]    s_now_ms,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_buzzer_on,
    output logic [bps_pkg::PAT_W-1:0]     m_pattern_in_use,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bps_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bps_pkg::CFG_W-1:0]     cfg_data
);

    bps_pkg::bps_cfg_t     cfg;
    bps_pkg::bps_rem_req_t rem_req;
    bps_pkg::bps_rem_rsp_t rem_rsp;

    bps_pkg::bps_state_t              state_reg, state_next;
    logic [bps_pkg::PAT_W-1:0]        held_reg, held_next;
    logic [bps_pkg::TIME_W-1:0]       start_reg, start_next;
    logic [bps_pkg::TIME_W-1:0]       t_reg, t_next;
    logic                             m_valid_reg, m_valid_next;
    logic                             m_on_reg, m_on_next;
    logic [bps_pkg::PAT_W-1:0]        m_pat_reg, m_pat_next;

    logic                             s_accept;
    logic                             out_free;
    logic [bps_pkg::TIME_W-1:0]       elapsed;
    logic [bps_pkg::CFG_W-1:0]        period;
    logic [bps_pkg::CFG_W-1:0]        on_time;
    logic                             beep;

    assign cfg_ready = 1'b1;

    bps_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid & cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    bps_rem u_rem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (rem_req),
        .rsp     (rem_rsp)
    );

    assign s_ready  = (state_reg == bps_pkg::ST_IDLE);
    assign s_accept = s_valid & s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // elapsed time: a new pattern starts its clock now
    assign elapsed = (s_mode != held_reg) ? '0 : (s_now_ms - start_reg);

    // period of the requested pattern
    always_comb begin
        case (s_mode)
            bps_pkg::PAT_SLOW:  period = cfg.slow_period;
            bps_pkg::PAT_FAST:  period = cfg.fast_period;
            bps_pkg::PAT_FAULT: period = cfg.fault_period;
            default:            period = '0;
        endcase
    end

    // on-time of the held pattern for slow and fast beep
    always_comb begin
        case (held_reg)
            bps_pkg::PAT_SLOW: on_time = cfg.slow_on_time;
            default:           on_time = cfg.fast_on_time;
        endcase
    end

    // buzzer decision from the cycle time
    always_comb begin
        case (held_reg)
            bps_pkg::PAT_SLOW,
            bps_pkg::PAT_FAST:  beep = t_reg < {16'd0, on_time};
            bps_pkg::PAT_FAULT: beep = (t_reg < {16'd0, cfg.fault_first_end}) ||
                                       ((t_reg >= {16'd0, cfg.fault_second_start}) &&
                                        (t_reg < {16'd0, cfg.fault_second_end}));
            default:            beep = 1'b0;
        endcase
    end

    // remainder request on accept of a pattern that needs reduction
    assign rem_req.start    = s_accept && (s_mode != bps_pkg::PAT_OFF) && (period != '0);
    assign rem_req.dividend = elapsed;
    assign rem_req.divisor  = period;

    // sequencer
    always_comb begin
        state_next   = state_reg;
        held_next    = held_reg;
        start_next   = start_reg;
        t_next       = t_reg;
        m_valid_next = m_valid_reg;
        m_on_next    = m_on_reg;
        m_pat_next   = m_pat_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            bps_pkg::ST_IDLE: begin
                if (s_accept) begin
                    held_next = s_mode;
                    if (s_mode != held_reg) begin
                        start_next = s_now_ms;
                    end
                    t_next = elapsed;
                    if (rem_req.start) begin
                        state_next = bps_pkg::ST_DIV;
                    end else begin
                        state_next = bps_pkg::ST_OUT;
                    end
                end
            end
            bps_pkg::ST_DIV: begin
                if (rem_rsp.done) begin
                    t_next     = {16'd0, rem_rsp.rem};
                    state_next = bps_pkg::ST_OUT;
                end
            end
            bps_pkg::ST_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_on_next    = beep;
                    m_pat_next   = held_reg;
                    state_next   = bps_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = bps_pkg::ST_IDLE;
            end
        endcase
    end

    // control state and held pattern
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bps_pkg::ST_IDLE;
            held_reg    <= bps_pkg::PAT_OFF;
            start_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            held_reg    <= held_next;
            start_reg   <= start_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        t_reg     <= t_next;
        m_on_reg  <= m_on_next;
        m_pat_reg <= m_pat_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_buzzer_on      = m_on_reg;
    assign m_pattern_in_use = m_pat_reg;

`ifndef SYNTHESIS
    // the remainder unit only answers while the sequencer waits for it
    a_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        rem_rsp.done |-> (state_reg == bps_pkg::ST_DIV))
        else $error("remainder done outside of division state");

    // the remainder unit is free whenever a new request can be taken
    a_rem_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bps_pkg::ST_IDLE) |-> !rem_rsp.busy)
        else $error("remainder unit busy while sequencer idle");

    // an accepted request always leaves the idle state
    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (state_reg != bps_pkg::ST_IDLE))
        else $error("sequencer stayed idle after accept");

    // a finished request lands in the output register and frees the input
    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bps_pkg::ST_OUT && out_free) |=>
            (m_valid_reg && state_reg == bps_pkg::ST_IDLE))
        else $error("result not loaded into output register");

    // the off pattern never sounds
    a_off_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_pattern_in_use == bps_pkg::PAT_OFF) |-> !m_buzzer_on)
        else $error("buzzer on while pattern is off");
`endif

endmodule

### sv/bps_cfg.sv
// timing register bank written through the configuration channel
module bps_cfg (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          wr_en,
    input  logic [bps_pkg::CFG_IDX_W-1:0] wr_index,
    input  logic [bps_pkg::CFG_W-1:0]     wr_data,
    output bps_pkg::bps_cfg_t             cfg
);

    bps_pkg::bps_cfg_t cfg_reg;
    bps_pkg::bps_cfg_t cfg_next;

    // decode the write, indexes beyond the bank are dropped
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (wr_index)
                bps_pkg::REG_SLOW_PERIOD:        cfg_next.slow_period        = wr_data;
                bps_pkg::REG_SLOW_ON_TIME:       cfg_next.slow_on_time       = wr_data;
                bps_pkg::REG_FAST_PERIOD:        cfg_next.fast_period        = wr_data;
                bps_pkg::REG_FAST_ON_TIME:       cfg_next.fast_on_time       = wr_data;
                bps_pkg::REG_FAULT_PERIOD:       cfg_next.fault_period       = wr_data;
                bps_pkg::REG_FAULT_FIRST_END:    cfg_next.fault_first_end    = wr_data;
                bps_pkg::REG_FAULT_SECOND_START: cfg_next.fault_second_start = wr_data;
                bps_pkg::REG_FAULT_SECOND_END:   cfg_next.fault_second_end   = wr_data;
                default: ;
            endcase
        end
    end

    // register bank with its reset values
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.slow_period        <= bps_pkg::RST_SLOW_PERIOD;
            cfg_reg.slow_on_time       <= bps_pkg::RST_SLOW_ON_TIME;
            cfg_reg.fast_period        <= bps_pkg::RST_FAST_PERIOD;
            cfg_reg.fast_on_time       <= bps_pkg::RST_FAST_ON_TIME;
            cfg_reg.fault_period       <= bps_pkg::RST_FAULT_PERIOD;
            cfg_reg.fault_first_end    <= bps_pkg::RST_FAULT_FIRST_END;
            cfg_reg.fault_second_start <= bps_pkg::RST_FAULT_SECOND_START;
            cfg_reg.fault_second_end   <= bps_pkg::RST_FAULT_SECOND_END;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### sv/bps_rem.sv
// bit-serial restoring remainder unit, one dividend bit per cycle
module bps_rem (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  bps_pkg::bps_rem_req_t req,
    output bps_pkg::bps_rem_rsp_t rsp
);

    logic                        busy_reg,  busy_next;
    logic                        done_reg,  done_next;
    logic [bps_pkg::CNT_W-1:0]   cnt_reg,   cnt_next;
    logic [bps_pkg::TIME_W-1:0]  dvd_reg,   dvd_next;
    logic [bps_pkg::CFG_W-1:0]   dvs_reg,   dvs_next;
    logic [bps_pkg::CFG_W-1:0]   rem_reg,   rem_next;
    logic [bps_pkg::CFG_W:0]     trial;
    logic [bps_pkg::CFG_W:0]     diff;

    // shift in the next dividend bit and try one subtract
    assign trial = {rem_reg, dvd_reg[bps_pkg::TIME_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        if (busy_reg) begin
            dvd_next = {dvd_reg[bps_pkg::TIME_W-2:0], 1'b0};
            // partial remainder stays below the divisor, so 16 bits hold it
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = diff[bps_pkg::CFG_W-1:0];
            end else begin
                rem_next = trial[bps_pkg::CFG_W-1:0];
            end
            cnt_next = cnt_reg - bps_pkg::CNT_W'(1);
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end else if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = bps_pkg::CNT_W'(bps_pkg::TIME_W - 1);
            dvd_next  = req.dividend;
            dvs_next  = req.divisor;
            rem_next  = '0;
        end
    end

    // control state resets, datapath does not
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg;

endmodule

### tb/beep_pattern_sequencer_top_test.sv
`timescale 1ns / 100ps
// testbench for the beep pattern sequencer: directed and random requests checked against a pattern predictor
module beep_pattern_sequencer_top_test;

    localparam int NUM_TIMING_REGS = 8;
    // indexes past the register bank, writes there must change nothing
    localparam logic [bps_pkg::CFG_IDX_W-1:0] REG_UNUSED_LO = 4'd8;
    localparam logic [bps_pkg::CFG_IDX_W-1:0] REG_UNUSED_HI = 4'd15;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 400;
    localparam int STALL_LIMIT   = 5000;
    localparam int PHASE_WORDS   = 370;

    typedef struct packed {
        logic                      buzzer_on;
        logic [bps_pkg::PAT_W-1:0] pattern_in_use;
    } buzzer_word_t;

    logic                          aclk      = 1'b0;
    logic                          aresetn   = 1'b0;
    logic                          s_valid   = 1'b0;
    logic [bps_pkg::PAT_W-1:0]     s_mode    = '0;
    logic [bps_pkg::TIME_W-1:0]    s_now_ms  = '0;
    logic                          m_ready   = 1'b0;
    logic                          cfg_valid = 1'b0;
    logic [bps_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [bps_pkg::CFG_W-1:0]     cfg_data  = '0;
    logic                          s_ready;
    logic                          m_valid;
    logic                          m_buzzer_on;
    logic [bps_pkg::PAT_W-1:0]     m_pattern_in_use;
    logic                          cfg_ready;

    // predictor state: timing registers, held pattern and its start time
    logic [bps_pkg::CFG_W-1:0]  timing_regs [2**bps_pkg::CFG_IDX_W];
    logic [bps_pkg::PAT_W-1:0]  held_pattern;
    logic [bps_pkg::TIME_W-1:0] pattern_start_ms;
    buzzer_word_t               pending_words [$];
    buzzer_word_t               want;

    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    bit hold_request   = 1'b0;
    int hold_left      = 0;
    int mismatch_count = 0;
    int stall_cycles   = 0;

    beep_pattern_sequencer_top DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_mode           (s_mode),
        .s_now_ms         (s_now_ms),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_buzzer_on      (m_buzzer_on),
        .m_pattern_in_use (m_pattern_in_use),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always #5 aclk = ~aclk;

    // position inside the pattern cycle, a zero period means no reduction
    function automatic logic [bps_pkg::TIME_W-1:0] cycle_ms(
        logic [bps_pkg::TIME_W-1:0] elapsed, logic [bps_pkg::CFG_W-1:0] period);
        if (period == '0) return elapsed;
        return elapsed % {16'd0, period};
    endfunction

    // buzzer word for one request, restarting the pattern clock on a new pattern
    function automatic buzzer_word_t predict_buzzer(logic [bps_pkg::PAT_W-1:0] mode,
                                                    logic [bps_pkg::TIME_W-1:0] now_ms);
        logic [bps_pkg::TIME_W-1:0] elapsed;
        logic [bps_pkg::TIME_W-1:0] t;
        buzzer_word_t               word;
        if (mode != held_pattern) begin
            held_pattern     = mode;
            pattern_start_ms = now_ms;
        end
        elapsed             = now_ms - pattern_start_ms;
        word.pattern_in_use = held_pattern;
        word.buzzer_on      = 1'b0;
        case (held_pattern)
            bps_pkg::PAT_SLOW: begin
                t = cycle_ms(elapsed, timing_regs[bps_pkg::REG_SLOW_PERIOD]);
                word.buzzer_on = t < timing_regs[bps_pkg::REG_SLOW_ON_TIME];
            end
            bps_pkg::PAT_FAST: begin
                t = cycle_ms(elapsed, timing_regs[bps_pkg::REG_FAST_PERIOD]);
                word.buzzer_on = t < timing_regs[bps_pkg::REG_FAST_ON_TIME];
            end
            bps_pkg::PAT_FAULT: begin
                t = cycle_ms(elapsed, timing_regs[bps_pkg::REG_FAULT_PERIOD]);
                word.buzzer_on = (t < timing_regs[bps_pkg::REG_FAULT_FIRST_END]) ||
                                 ((t >= timing_regs[bps_pkg::REG_FAULT_SECOND_START]) &&
                                  (t < timing_regs[bps_pkg::REG_FAULT_SECOND_END]));
            end
            default: word.buzzer_on = 1'b0;
        endcase
        return word;
    endfunction

    // receiver: random idling, or a long hold-off when one is requested
    always @(posedge aclk) begin
        if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // track config and requests, compare every returned word, watch for a hang
    always @(posedge aclk) begin
        if (!aresetn) begin
            timing_regs[bps_pkg::REG_SLOW_PERIOD]        = bps_pkg::RST_SLOW_PERIOD;
            timing_regs[bps_pkg::REG_SLOW_ON_TIME]       = bps_pkg::RST_SLOW_ON_TIME;
            timing_regs[bps_pkg::REG_FAST_PERIOD]        = bps_pkg::RST_FAST_PERIOD;
            timing_regs[bps_pkg::REG_FAST_ON_TIME]       = bps_pkg::RST_FAST_ON_TIME;
            timing_regs[bps_pkg::REG_FAULT_PERIOD]       = bps_pkg::RST_FAULT_PERIOD;
            timing_regs[bps_pkg::REG_FAULT_FIRST_END]    = bps_pkg::RST_FAULT_FIRST_END;
            timing_regs[bps_pkg::REG_FAULT_SECOND_START] = bps_pkg::RST_FAULT_SECOND_START;
            timing_regs[bps_pkg::REG_FAULT_SECOND_END]   = bps_pkg::RST_FAULT_SECOND_END;
            held_pattern     = bps_pkg::PAT_OFF;
            pattern_start_ms = '0;
            pending_words.delete();
        end else begin
            if (cfg_valid && cfg_ready && cfg_index < NUM_TIMING_REGS)
                timing_regs[cfg_index] = cfg_data;
            if (s_valid && s_ready)
                pending_words.push_back(predict_buzzer(s_mode, s_now_ms));
            if (m_valid && m_ready) begin
                if (pending_words.size() == 0) begin
                    $display("%0t: unexpected word, buzzer_on %0d pattern %0d",
                             $time, m_buzzer_on, m_pattern_in_use);
                    mismatch_count++;
                end else begin
                    want = pending_words.pop_front();
                    if (m_buzzer_on !== want.buzzer_on) begin
                        $display("%0t: buzzer_on expected %0d actual %0d",
                                 $time, want.buzzer_on, m_buzzer_on);
                        mismatch_count++;
                    end
                    if (m_pattern_in_use !== want.pattern_in_use) begin
                        $display("%0t: pattern_in_use expected %0d actual %0d",
                                 $time, want.pattern_in_use, m_pattern_in_use);
                        mismatch_count++;
                    end
                end
            end
        end
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d words outstanding",
                     $time, stall_cycles, pending_words.size());
            $display("** beep_pattern_sequencer_top: FAILED **");
            $finish;
        end
    end

    // offer one request word, with optional idle cycles ahead of it
    task automatic send_request(input logic [bps_pkg::PAT_W-1:0] mode,
                                input logic [bps_pkg::TIME_W-1:0] now_ms);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid  <= 1'b1;
        s_mode   <= mode;
        s_now_ms <= now_ms;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic write_timing_reg(input logic [bps_pkg::CFG_IDX_W-1:0] index,
                                    input logic [bps_pkg::CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // stop sending and let every outstanding word come back
    task automatic wait_until_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_words.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [bps_pkg::CFG_W-1:0] pick_period();
        case ($urandom_range(9))
            0:       return '0;
            1:       return 16'd1;
            2:       return 16'hFFFF;
            3, 4, 5: return bps_pkg::CFG_W'($urandom_range(2, 40));
            default: return bps_pkg::CFG_W'($urandom_range(41, 3000));
        endcase
    endfunction

    // window edges mostly inside the period, sometimes empty or beyond it
    function automatic logic [bps_pkg::CFG_W-1:0] pick_window(
        logic [bps_pkg::CFG_W-1:0] period);
        int span;
        span = (period == '0 || period > 16'd3000) ? 3000 : period;
        case ($urandom_range(7))
            0:       return '0;
            1:       return 16'hFFFF;
            default: return bps_pkg::CFG_W'($urandom_range(0, span + span / 4));
        endcase
    endfunction

    task automatic load_random_timing();
        logic [bps_pkg::CFG_W-1:0] period;
        period = pick_period();
        write_timing_reg(bps_pkg::REG_SLOW_PERIOD, period);
        write_timing_reg(bps_pkg::REG_SLOW_ON_TIME, pick_window(period));
        period = pick_period();
        write_timing_reg(bps_pkg::REG_FAST_PERIOD, period);
        write_timing_reg(bps_pkg::REG_FAST_ON_TIME, pick_window(period));
        period = pick_period();
        write_timing_reg(bps_pkg::REG_FAULT_PERIOD, period);
        write_timing_reg(bps_pkg::REG_FAULT_FIRST_END, pick_window(period));
        write_timing_reg(bps_pkg::REG_FAULT_SECOND_START, pick_window(period));
        write_timing_reg(bps_pkg::REG_FAULT_SECOND_END, pick_window(period));
    endtask

    // mostly a running clock with short steps and a held pattern, some jumps and noise
    task automatic send_random_requests(input int count);
        logic [bps_pkg::PAT_W-1:0]  mode;
        logic [bps_pkg::TIME_W-1:0] clock_ms;
        int                         roll;
        clock_ms = $urandom;
        mode     = bps_pkg::PAT_W'($urandom_range(3));
        repeat (count) begin
            roll = $urandom_range(99);
            if (roll < 8)
                clock_ms = $urandom;
            else if (roll < 25)
                clock_ms += $urandom_range(61, 4000);
            else
                clock_ms += $urandom_range(0, 60);
            if ($urandom_range(99) < 20)
                mode = bps_pkg::PAT_W'($urandom_range(3));
            if ($urandom_range(99) < 5)
                send_request(bps_pkg::PAT_W'($urandom_range(3)), $urandom);
            else
                send_request(mode, clock_ms);
        end
    endtask

    // reset timing: on-time edges, wrap of the time counter, both fault windows
    task automatic test_default_patterns();
        send_request(bps_pkg::PAT_OFF, 32'hFFFF_FFFF);
        send_request(bps_pkg::PAT_SLOW, 32'hFFFF_FF00);
        send_request(bps_pkg::PAT_SLOW, 32'hFFFF_FFC7);
        send_request(bps_pkg::PAT_SLOW, 32'hFFFF_FFC8);
        send_request(bps_pkg::PAT_SLOW, 32'h0000_02E8);
        send_request(bps_pkg::PAT_FAST, 32'h1234_5678);
        send_request(bps_pkg::PAT_FAST, 32'h1234_56DC);
        send_request(bps_pkg::PAT_FAST, 32'h1234_5772);
        send_request(bps_pkg::PAT_FAULT, 32'd0);
        send_request(bps_pkg::PAT_FAULT, 32'd149);
        send_request(bps_pkg::PAT_FAULT, 32'd150);
        send_request(bps_pkg::PAT_FAULT, 32'd299);
        send_request(bps_pkg::PAT_FAULT, 32'd300);
        send_request(bps_pkg::PAT_FAULT, 32'd449);
        send_request(bps_pkg::PAT_FAULT, 32'd450);
        send_request(bps_pkg::PAT_FAULT, 32'd2000);
        send_request(bps_pkg::PAT_OFF, 32'd5);
    endtask

    // zero period, zero on-time, inverted second window, writes past the bank
    task automatic test_special_settings();
        wait_until_idle();
        write_timing_reg(bps_pkg::REG_SLOW_PERIOD, 16'd0);
        write_timing_reg(bps_pkg::REG_SLOW_ON_TIME, 16'hFFFF);
        write_timing_reg(bps_pkg::REG_FAST_ON_TIME, 16'd0);
        write_timing_reg(bps_pkg::REG_FAULT_FIRST_END, 16'd0);
        write_timing_reg(bps_pkg::REG_FAULT_SECOND_START, 16'd500);
        write_timing_reg(bps_pkg::REG_FAULT_SECOND_END, 16'd400);
        write_timing_reg(REG_UNUSED_LO, 16'd7);
        write_timing_reg(REG_UNUSED_HI, 16'd9000);
        send_request(bps_pkg::PAT_SLOW, 32'd1000);
        send_request(bps_pkg::PAT_SLOW, 32'd66534);
        send_request(bps_pkg::PAT_SLOW, 32'd66535);
        send_request(bps_pkg::PAT_SLOW, 32'h8000_03E8);
        send_request(bps_pkg::PAT_FAST, 32'd7);
        send_request(bps_pkg::PAT_FAULT, 32'd0);
        send_request(bps_pkg::PAT_FAULT, 32'd450);
        send_request(bps_pkg::PAT_FAULT, 32'd500);
    endtask

    // receiver stalls long enough for the block to fill and hold off requests
    task automatic test_output_backpressure();
        wait_until_idle();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request  = 1'b1;
        send_random_requests(24);
        wait_until_idle();
    endtask

    // three phases of random traffic under different timing and idling
    task automatic test_random_traffic();
        load_random_timing();
        send_idle_pct = 37;
        recv_idle_pct = 82;
        send_random_requests(PHASE_WORDS);

        // extreme register values, with a full pause halfway
        wait_until_idle();
        write_timing_reg(bps_pkg::REG_SLOW_PERIOD, 16'd1);
        write_timing_reg(bps_pkg::REG_SLOW_ON_TIME, 16'd1);
        write_timing_reg(bps_pkg::REG_FAST_PERIOD, 16'hFFFF);
        write_timing_reg(bps_pkg::REG_FAST_ON_TIME, 16'hFFFF);
        write_timing_reg(bps_pkg::REG_FAULT_PERIOD, 16'd0);
        write_timing_reg(bps_pkg::REG_FAULT_FIRST_END, 16'hFFFF);
        write_timing_reg(bps_pkg::REG_FAULT_SECOND_START, 16'd0);
        write_timing_reg(bps_pkg::REG_FAULT_SECOND_END, 16'hFFFF);
        send_idle_pct = 82;
        recv_idle_pct = 37;
        send_random_requests(PHASE_WORDS / 2);
        wait_until_idle();
        send_random_requests(PHASE_WORDS / 2);

        wait_until_idle();
        load_random_timing();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random_requests(PHASE_WORDS);
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_default_patterns();
        test_special_settings();
        test_output_backpressure();
        test_random_traffic();
        wait_until_idle();
        mismatch_count += pending_words.size();
        if (mismatch_count == 0)
            $display("** beep_pattern_sequencer_top: PASSED **");
        else
            $display("** beep_pattern_sequencer_top: FAILED **");
        $finish;
    end

endmodule
